FILE: design/psfr_pkg.sv
// psfr_pkg: payload, command and status types for the per-sender reorder buffer.
// No dependencies; used by psfr_ctrl, psfr_dp and per_sender_fifo_reorder.
package psfr_pkg;

    localparam int SENDER_W = 7;
    localparam int SEQ_W    = 32;

    // Expected sequence number for every sender after reset
    localparam logic [SEQ_W-1:0] SEQ_START = 32'd1;

    typedef struct packed {
        logic [SENDER_W-1:0] sender_id;
        logic [SEQ_W-1:0]    seq_number;
    } pkt_t;

    typedef struct packed {
        logic [SENDER_W-1:0] out_sender;
        logic [SEQ_W-1:0]    out_seq;
        logic                last_of_run;
    } dlv_t;

    // Controller to datapath
    typedef struct packed {
        logic clear_step;   // write reset value to one table entry
        logic capture;      // beat accepted: latch packet, read sender entry
        logic eval;         // check arrival against the entry read
        logic drain;        // load one delivery into the output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;   // clearing pass at its final entry
        logic run_start;    // arrival kept and fills the expected slot
        logic run_end;      // delivery being loaded closes the run
        logic out_free;     // output register can take a delivery
    } sts_t;

endpackage

FILE: design/psfr_ctrl.sv
// psfr_ctrl: sequencer for the reorder buffer (clear, idle, evaluate, drain).
// Depends on psfr_pkg for the command and status structs.
module psfr_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pkt_valid,
    output logic            pkt_stall,
    input  psfr_pkg::sts_t  sts,
    output psfr_pkg::cmd_t  cmd
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EVAL  = 2'd2;
    localparam logic [1:0] ST_DRAIN = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign pkt_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        cmd.clear_step = (state_reg == ST_CLEAR);
        cmd.capture    = (state_reg == ST_IDLE) && pkt_valid;
        cmd.eval       = (state_reg == ST_EVAL);
        cmd.drain      = (state_reg == ST_DRAIN) && sts.out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (pkt_valid)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                state_next = sts.run_start ? ST_DRAIN : ST_IDLE;
            end
            ST_DRAIN:
            begin
                if (sts.out_free && sts.run_end)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

endmodule

FILE: design/psfr_dp.sv
// psfr_dp: sender table memory, arrival checks, run registers and output register.
// Depends on psfr_pkg; driven by psfr_ctrl through cmd_t / sts_t.
module psfr_dp
#(
    parameter int MAX_SENDERS = 128,
    parameter int WINDOW      = 32
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  psfr_pkg::pkt_t  pkt,
    input  psfr_pkg::cmd_t  cmd,
    output psfr_pkg::sts_t  sts,
    output logic            dlv_valid,
    input  logic            dlv_stall,
    output psfr_pkg::dlv_t  dlv
);

    localparam int AW = $clog2(MAX_SENDERS);
    localparam int IW = $clog2(WINDOW);
    localparam int SW = psfr_pkg::SEQ_W;
    localparam int EW = WINDOW + SW;

    // entry = {pending window, next expected}
    logic [EW-1:0] mem [MAX_SENDERS];

    logic [AW-1:0]              clr_cnt_reg;
    logic [EW-1:0]              rd_data_reg;
    logic [psfr_pkg::SENDER_W-1:0] sid_reg;
    logic [SW-1:0]              seq_reg;
    logic                       known_reg;
    logic [SW-1:0]              nxt_reg;
    logic [WINDOW-1:0]          win_reg;
    logic                       out_valid_reg;
    psfr_pkg::dlv_t             out_data_reg;

    logic [SW-1:0]     cur_nxt;
    logic [WINDOW-1:0] cur_win;
    logic [SW-1:0]     offset;
    logic              in_win;
    logic [IW-1:0]     bidx;
    logic              keep;
    logic [WINDOW-1:0] win_new;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [EW-1:0]     wr_data;

    assign cur_nxt = rd_data_reg[SW-1:0];
    assign cur_win = rd_data_reg[EW-1:SW];
    assign offset  = seq_reg - cur_nxt;
    assign in_win  = (seq_reg >= cur_nxt) && (offset < SW'(WINDOW));
    assign bidx    = offset[IW-1:0];
    assign keep    = known_reg && in_win && !cur_win[bidx];
    assign win_new = cur_win | (WINDOW'(1) << bidx);

    always_comb
    begin
        sts.clear_last = (clr_cnt_reg == AW'(MAX_SENDERS - 1));
        sts.run_start  = keep && win_new[0];
        sts.run_end    = !win_reg[1];
        sts.out_free   = !out_valid_reg || !dlv_stall;
    end

    // single write port: clearing pass, gap record, or end-of-run write-back
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = AW'(sid_reg);
        wr_data = {win_new, cur_nxt};
        if (cmd.clear_step)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = {{WINDOW{1'b0}}, psfr_pkg::SEQ_START};
        end
        else if (cmd.eval && keep && !win_new[0])
        begin
            wr_en = 1'b1;
        end
        else if (cmd.drain && sts.run_end)
        begin
            wr_en   = 1'b1;
            wr_data = {win_reg >> 1, nxt_reg + SW'(1)};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.capture)
            rd_data_reg <= mem[AW'(pkt.sender_id)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (cmd.clear_step)
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sid_reg   <= pkt.sender_id;
            seq_reg   <= pkt.seq_number;
            known_reg <= (int'(pkt.sender_id) < MAX_SENDERS);
        end
        if (cmd.eval)
        begin
            nxt_reg <= cur_nxt;
            win_reg <= win_new;
        end
        else if (cmd.drain)
        begin
            nxt_reg <= nxt_reg + SW'(1);
            win_reg <= win_reg >> 1;
        end
        if (cmd.drain)
        begin
            out_data_reg.out_sender  <= sid_reg;
            out_data_reg.out_seq     <= nxt_reg;
            out_data_reg.last_of_run <= sts.run_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.drain)
            out_valid_reg <= 1'b1;
        else if (!dlv_stall)
            out_valid_reg <= 1'b0;
    end

    assign dlv_valid = out_valid_reg;
    assign dlv       = out_data_reg;

    // a run can only begin with the packet that was expected
    a_run_starts_at_expected: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.eval && sts.run_start) |-> (seq_reg == cur_nxt))
        else $error("run started by a packet other than the expected one");

    // inside a run the next beat follows at once with the next sequence number
    a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (dlv_valid && !dlv_stall && !dlv.last_of_run) |=>
            (dlv_valid && dlv.out_seq == $past(dlv.out_seq) + SW'(1)
             && dlv.out_sender == $past(dlv.out_sender)))
        else $error("delivery run broken");

    // no table write while a new packet is being looked up
    a_no_write_on_capture: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> !wr_en)
        else $error("table written during packet lookup");

endmodule

FILE: design/per_sender_fifo_reorder.sv
// Per-sender FIFO reorder buffer: top level joining psfr_ctrl and psfr_dp.
// Depends on psfr_pkg for the packet, delivery, command and status types.
//
// Packets arrive in any order, each with a sender number and a sequence
// number; for every sender the block holds the next expected number
// (1 after reset) and a WINDOW-bit map of packets already seen ahead of it.
// After each arrival it delivers, in order, the run of consecutive numbers
// starting at the expected one, flagging the final beat with last_of_run.
// Stale, duplicate, out-of-window packets and unknown senders are dropped
// without any delivery. After reset the sender table is swept, one entry
// per cycle, while pkt_stall is held high. Then each packet is accepted
// with its sender entry read into a register, then checked, a gap being
// recorded by a read-modify-write of the sender entry; the deliveries of
// its run are then loaded one by one while dlv_stall is low, the last
// writing back the sender entry. The output register lets the next packet be
// accepted while the last beat of a run still waits to be taken.
module per_sender_fifo_reorder
#(
    parameter int MAX_SENDERS = 128,
    parameter int WINDOW      = 32
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pkt_valid,
    output logic            pkt_stall,
    input  psfr_pkg::pkt_t  pkt,
    output logic            dlv_valid,
    input  logic            dlv_stall,
    output psfr_pkg::dlv_t  dlv
);

    psfr_pkg::cmd_t cmd;
    psfr_pkg::sts_t sts;

    // sequencer: clearing pass, lookup, check, drain
    psfr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (pkt_valid),
        .pkt_stall (pkt_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // sender table, window logic and delivery register
    psfr_dp
    #(
        .MAX_SENDERS (MAX_SENDERS),
        .WINDOW      (WINDOW)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt       (pkt),
        .cmd       (cmd),
        .sts       (sts),
        .dlv_valid (dlv_valid),
        .dlv_stall (dlv_stall),
        .dlv       (dlv)
    );

endmodule

FILE: dv/psfr_delivery_checker.sv
// psfr_delivery_checker: watches the packet and delivery channels of the per-sender
// reorder buffer, predicts every delivery and compares beats field by field.
// Depends on psfr_pkg for the packet and delivery types.
module psfr_delivery_checker
#(
    parameter int SENDERS = 128,
    parameter int WINDOW  = 32
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pkt_valid,
    input  logic            pkt_stall,
    input  psfr_pkg::pkt_t  pkt,
    input  logic            dlv_valid,
    input  logic            dlv_stall,
    input  psfr_pkg::dlv_t  dlv,
    output int              fail_count,
    output int              due_count,
    output int              pkt_count,
    output int              drop_count,
    output int              dlv_count,
    output int              longest_run
);
    timeunit 1ns;
    timeprecision 1ps;

    // Per-sender shadow: sequence number awaited and map of arrivals held ahead of it
    logic [psfr_pkg::SEQ_W-1:0] want_seq  [SENDERS];
    logic [WINDOW-1:0]          held_bits [SENDERS];
    psfr_pkg::dlv_t             due_dlv   [$];

    // Record one arrival and queue the run of deliveries it releases
    function automatic void absorb_packet(input psfr_pkg::pkt_t p);
        logic [psfr_pkg::SEQ_W-1:0] head;
        logic [psfr_pkg::SEQ_W-1:0] gap;
        logic [WINDOW-1:0]          bits;
        psfr_pkg::dlv_t             beat;
        int                         run;
        pkt_count++;
        head = want_seq[p.sender_id];
        bits = held_bits[p.sender_id];
        gap  = p.seq_number - head;
        run  = 0;
        if (p.sender_id >= SENDERS || p.seq_number < head || gap >= WINDOW || bits[gap])
            drop_count++;
        else
        begin
            bits[gap] = 1'b1;
            while (bits[0] && run < WINDOW)
            begin
                beat.out_sender  = p.sender_id;
                beat.out_seq     = head;
                beat.last_of_run = (run == WINDOW - 1) || !bits[1];
                due_dlv.insert(due_dlv.size(), beat);
                head++;
                bits = bits >> 1;
                run++;
            end
            want_seq[p.sender_id]  = head;
            held_bits[p.sender_id] = bits;
            if (run > longest_run)
                longest_run = run;
        end
    endfunction

    always @(posedge clk)
    begin : watch
        psfr_pkg::dlv_t want;
        int             s;
        if (!rst_n)
        begin
            for (s = 0; s < SENDERS; s++)
            begin
                want_seq[s]  = psfr_pkg::SEQ_START;
                held_bits[s] = '0;
            end
            due_dlv.delete();
            fail_count  = 0;
            due_count   = 0;
            pkt_count   = 0;
            drop_count  = 0;
            dlv_count   = 0;
            longest_run = 0;
        end
        else
        begin
            if (dlv_valid && !dlv_stall)
            begin
                dlv_count++;
                if (due_dlv.size() == 0)
                begin
                    $error("delivery with none due: out_sender %0d out_seq %0d",
                           dlv.out_sender, dlv.out_seq);
                    fail_count++;
                end
                else
                begin
                    want = due_dlv.pop_front();
                    if (dlv.out_sender !== want.out_sender)
                    begin
                        $error("out_sender: expected %0d, got %0d",
                               want.out_sender, dlv.out_sender);
                        fail_count++;
                    end
                    if (dlv.out_seq !== want.out_seq)
                    begin
                        $error("out_seq: expected %0d, got %0d", want.out_seq, dlv.out_seq);
                        fail_count++;
                    end
                    if (dlv.last_of_run !== want.last_of_run)
                    begin
                        $error("last_of_run: expected %0b, got %0b",
                               want.last_of_run, dlv.last_of_run);
                        fail_count++;
                    end
                end
            end
            // a beat delivered at this edge can never come from a packet taken at it
            if (pkt_valid && !pkt_stall)
                absorb_packet(pkt);
            due_count = due_dlv.size();
        end
    end

endmodule

FILE: dv/tb_per_sender_fifo_reorder.sv
// tb_per_sender_fifo_reorder: clock, reset, packet stimulus, receiver stalls and verdict
// for the per-sender reorder buffer. Depends on psfr_pkg, per_sender_fifo_reorder and
// psfr_delivery_checker.
module tb_per_sender_fifo_reorder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SENDERS     = 128;
    localparam int WINDOW      = 32;
    localparam int PHASE_ITEMS = 34;    // in-stream packets per random phase
    localparam int MAX_BURST   = 8;     // keeps a deferred head plus two bursts inside the window
    localparam int HOLD_CYCLES = 300;   // long receiver hold-off to back the input up
    localparam int QUIET_LIMIT = 3000;  // cycles with no beat on either channel
    localparam int TAIL_CYCLES = 40;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;
    typedef enum logic [1:0] {NOISE_STALE, NOISE_BEYOND, NOISE_WILD} noise_e;

    logic           clk;
    logic           rst_n;
    logic           pkt_valid;
    logic           pkt_stall;
    psfr_pkg::pkt_t pkt;
    logic           dlv_valid;
    logic           dlv_stall;
    psfr_pkg::dlv_t dlv;

    idle_mode_e idle_mode;
    logic       hold_req;
    int         quiet = 0;
    int         counted;

    int         fails;
    int         due;
    int         pkts;
    int         drops;
    int         dlvs;
    int         longest;

    // Sequence number each sender's stream continues from, as far as stimulus knows
    logic [psfr_pkg::SEQ_W-1:0]    stream_head [SENDERS];

    // One packet held back from a burst and sent an iteration later, leaving a gap meanwhile
    logic                          defer_live;
    logic [psfr_pkg::SENDER_W-1:0] defer_id;
    logic [psfr_pkg::SEQ_W-1:0]    defer_seq;
    int                            defer_age;

    per_sender_fifo_reorder
    #(
        .MAX_SENDERS (SENDERS),
        .WINDOW      (WINDOW)
    )
    i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (pkt_valid),
        .pkt_stall (pkt_stall),
        .pkt       (pkt),
        .dlv_valid (dlv_valid),
        .dlv_stall (dlv_stall),
        .dlv       (dlv)
    );

    psfr_delivery_checker
    #(
        .SENDERS (SENDERS),
        .WINDOW  (WINDOW)
    )
    i_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .pkt_valid   (pkt_valid),
        .pkt_stall   (pkt_stall),
        .pkt         (pkt),
        .dlv_valid   (dlv_valid),
        .dlv_stall   (dlv_stall),
        .dlv         (dlv),
        .fail_count  (fails),
        .due_count   (due),
        .pkt_count   (pkts),
        .drop_count  (drops),
        .dlv_count   (dlvs),
        .longest_run (longest)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Watchdog: ends the run when neither channel has moved a beat for too long.
    // The clearing sweep after reset and the long hold-off both sit well inside the limit.
    always @(posedge clk)
    begin
        if (!rst_n || (pkt_valid && !pkt_stall) || (dlv_valid && !dlv_stall))
            quiet <= 0;
        else if (quiet + 1 >= QUIET_LIMIT)
        begin
            $display("watchdog: no beat on either channel for %0d cycles", QUIET_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    // Random idle draw for either side, by the current idling phase
    function automatic bit idle_draw(input bit receiver);
        int unsigned pct;
        if (idle_mode == IDLE_BOTH)
            pct = 12;
        else if (idle_mode == (receiver ? IDLE_RECEIVER : IDLE_SENDER))
            pct = 74;
        else
            pct = 0;
        return $urandom_range(99) < pct;
    endfunction

    // Mostly a handful of busy senders, so streams get deep; otherwise any sender
    function automatic logic [psfr_pkg::SENDER_W-1:0] pick_sender();
        if ($urandom_range(99) < 60)
            return psfr_pkg::SENDER_W'($urandom_range(7) * 18);
        return psfr_pkg::SENDER_W'($urandom_range(SENDERS - 1));
    endfunction

    // Receiver side: random stalls, plus one long hold-off on request.
    // The hold-off is counted here so the sender keeps offering packets meanwhile.
    initial
    begin : receiver
        int hold_left;
        bit hold_used;
        hold_left = 0;
        hold_used = 1'b0;
        dlv_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                dlv_stall <= 1'b1;
                hold_left--;
            end
            else if (hold_req && !hold_used)
            begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                dlv_stall <= 1'b1;
            end
            else
                dlv_stall <= idle_draw(1'b1);
        end
    end

    // Offer one packet beat. Entered and left at a falling edge; valid is only
    // touched once per edge, so back-to-back beats keep it high throughout.
    task automatic offer_pkt(input logic [psfr_pkg::SENDER_W-1:0] id,
                             input logic [psfr_pkg::SEQ_W-1:0] seq);
        if (idle_draw(1'b0))
        begin
            pkt_valid <= 1'b0;
            do
                @(negedge clk);
            while (idle_draw(1'b0));
        end
        pkt_valid <= 1'b1;
        pkt       <= psfr_pkg::pkt_t'{sender_id: id, seq_number: seq};
        do
            @(posedge clk);
        while (pkt_stall);
        @(negedge clk);
    endtask

    // Send k consecutive sequence numbers of one sender's stream, shuffled (or
    // highest first), sometimes with a repeated beat or the head held back.
    task automatic run_burst(input int unsigned k, input bit reversed);
        logic [psfr_pkg::SENDER_W-1:0] id;
        logic [psfr_pkg::SEQ_W-1:0]    seqs [$];
        logic [psfr_pkg::SEQ_W-1:0]    swap;
        int unsigned                   i;
        int unsigned                   j;
        id = pick_sender();
        for (i = 0; i < k; i++)
            seqs.insert(seqs.size(),
                        reversed ? stream_head[id] + k - 1 - i : stream_head[id] + i);
        if (!reversed)
        begin
            for (i = k - 1; i > 0; i--)
            begin
                j       = $urandom_range(i);
                swap    = seqs[i];
                seqs[i] = seqs[j];
                seqs[j] = swap;
            end
            // hold back the expected head: the rest sits pending until it turns up
            if (!defer_live && k > 1 && $urandom_range(99) < 15)
            begin
                for (i = 0; i < seqs.size(); i++)
                    if (seqs[i] == stream_head[id])
                        j = i;
                seqs.delete(j);
                defer_live = 1'b1;
                defer_id   = id;
                defer_seq  = stream_head[id];
                defer_age  = 0;
            end
            // duplicate beat somewhere in the burst
            if ($urandom_range(99) < 20)
                seqs.insert($urandom_range(seqs.size()), seqs[$urandom_range(seqs.size() - 1)]);
        end
        stream_head[id] += k;
        counted += k;
        foreach (seqs[n])
            offer_pkt(id, seqs[n]);
    endtask

    // A noise packet, mostly dropped: stale or beyond the window as stimulus knows the stream, or fully random
    task automatic send_noise();
        logic [psfr_pkg::SENDER_W-1:0] id;
        logic [psfr_pkg::SEQ_W-1:0]    seq;
        noise_e                        kind;
        id   = psfr_pkg::SENDER_W'($urandom());
        kind = noise_e'($urandom_range(2));
        case (kind)
            NOISE_STALE:  seq = psfr_pkg::SEQ_W'($urandom_range(stream_head[id] - 1));
            NOISE_BEYOND: seq = stream_head[id] + WINDOW + $urandom_range(64);
            default:      seq = $urandom();
        endcase
        offer_pkt(id, seq);
    endtask

    // One idling phase: mostly well-formed bursts, a quarter noise
    task automatic random_phase(input idle_mode_e mode);
        int goal;
        idle_mode <= mode;
        goal = counted + PHASE_ITEMS;
        while (counted < goal)
        begin
            if ($urandom_range(99) < 75)
                run_burst($urandom_range(1, MAX_BURST), 1'b0);
            else
                send_noise();
            if (defer_live)
            begin
                if (defer_age >= 1)
                begin
                    defer_live = 1'b0;
                    offer_pkt(defer_id, defer_seq);
                end
                else
                    defer_age++;
            end
        end
        if (defer_live)
        begin
            defer_live = 1'b0;
            offer_pkt(defer_id, defer_seq);
        end
    endtask

    initial
    begin : stimulus
        int s;
        rst_n      = 1'b0;
        pkt_valid  = 1'b0;
        pkt        = '0;
        idle_mode  = IDLE_NONE;
        hold_req   = 1'b0;
        counted    = 0;
        defer_live = 1'b0;
        defer_id   = '0;
        defer_seq  = '0;
        defer_age  = 0;
        for (s = 0; s < SENDERS; s++)
            stream_head[s] = psfr_pkg::SEQ_START;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: block still sweeping its table, so the first beat waits on pkt_stall
        offer_pkt(7'd0,   32'd1);           // in order: single delivery
        offer_pkt(7'd0,   32'd1);           // stale, already delivered
        offer_pkt(7'd0,   32'd0);           // stale, zero
        offer_pkt(7'd0,   32'd3);           // gap remains, only recorded
        offer_pkt(7'd0,   32'd3);           // duplicate of a pending beat
        offer_pkt(7'd0,   32'd2 + WINDOW);  // just beyond the window
        offer_pkt(7'd0,   32'd1 + WINDOW);  // top slot of the window, recorded
        offer_pkt(7'd0,   32'd2);           // fills the gap: run of two
        offer_pkt(7'd0,   32'hFFFF_FFFF);   // far beyond
        offer_pkt(7'd127, 32'hFFFF_FFFF);
        offer_pkt(7'd127, 32'd1);
        offer_pkt(7'd127, 32'h8000_0000);
        offer_pkt(7'h55,  32'd1);
        offer_pkt(7'h2A,  32'd1);
        offer_pkt(7'h55,  32'h5555_5555);
        offer_pkt(7'h2A,  32'hAAAA_AAAA);
        stream_head[0]   = 32'd4;
        stream_head[127] = 32'd2;
        stream_head[85]  = 32'd2;
        stream_head[42]  = 32'd2;

        // Receiver holds off while a whole window is filled highest first; the last
        // beat releases a full-length run, and the next phase keeps offering behind it
        hold_req <= 1'b1;
        run_burst(WINDOW, 1'b1);

        random_phase(IDLE_NONE);
        random_phase(IDLE_SENDER);
        random_phase(IDLE_RECEIVER);
        random_phase(IDLE_BOTH);

        pkt_valid <= 1'b0;
        while (due != 0)
            @(negedge clk);
        // dropped packets may still be in flight after the last delivery
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Summary: %0d packets taken, %0d dropped (stale, duplicate, out of window),",
                 pkts, drops);
        $display("Summary: %0d deliveries checked, longest run %0d, idling in four phases",
                 dlvs, longest);
        if (fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: sim.f
design/psfr_pkg.sv
design/psfr_ctrl.sv
design/psfr_dp.sv
design/per_sender_fifo_reorder.sv
dv/psfr_delivery_checker.sv
dv/tb_per_sender_fifo_reorder.sv
